// File: hdl/bgc_pkg.sv
// Shared types and constants for the button gesture counter.
package bgc_pkg;

    // Configuration register reset values
    localparam logic [15:0] DEBOUNCE_RESET = 16'd60;
    localparam logic [7:0]  PRESCALE_RESET = 8'd2;
    localparam logic [7:0]  MODULUS_RESET  = 8'd5;

    // Saturation limit of the stable tick count and the top of the fade ramp
    localparam logic [15:0] STABLE_MAX = 16'hFFFF;
    localparam logic [7:0]  FADE_TOP   = 8'd255;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_PRESCALE = 2'd1,
        CFG_MODULUS  = 2'd2
    } bgc_cfg_idx_t;

    // Release action codes
    typedef enum logic [2:0] {
        ACT_NONE           = 3'd0,
        ACT_SHOW_REMAINING = 3'd1,
        ACT_COUNTED_UP     = 3'd2,
        ACT_LIGHT_ON       = 3'd3,
        ACT_LIGHT_OFF      = 3'd4
    } bgc_action_t;

    // Live configuration
    typedef struct packed {
        logic [15:0] debounce_ticks;
        logic [7:0]  fade_prescale;
        logic [7:0]  count_modulus;
    } bgc_cfg_t;

    // One result word
    typedef struct packed {
        logic [7:0]  duty;
        bgc_action_t action;
        logic [7:0]  remaining;
        logic [7:0]  tally;
        logic        light_on;
    } bgc_result_t;

endpackage

// File: hdl/button_gesture_counter_unit.sv
// Top level of the button gesture counter: input register, step engine, result register.
//
// Button gesture counter. Each input word is one timer tick carrying the raw
// active-low button level; each tick yields exactly one result word with the
// indicator duty, the release action, the remaining count, the counter value
// and the light state. One word is accepted per clock cycle. The input register
// holds the word, then one pass through the debounce/fade/classify logic loads
// the result register when there is room, and stalls on the output side back
// up through the input register. The configuration port is always ready and
// should only be written while no ticks are in flight.
module button_gesture_counter_unit
    import bgc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic        button_level,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  duty,
    output logic [2:0]  action,
    output logic [7:0]  remaining,
    output logic [7:0]  tally,
    output logic        light_on
);

    bgc_cfg_t    cfg;
    bgc_result_t step_result;
    bgc_result_t result_reg;
    logic        in_valid_reg;
    logic        level_reg;
    logic        out_valid_reg;
    logic        out_load;

    assign cfg_ready = 1'b1;

    bgc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Move a word from the input register to the result register when there is room
    assign out_load = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || out_load;

    bgc_engine u_engine (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .step   (out_load),
        .level  (level_reg),
        .result (step_result)
    );

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            level_reg <= button_level;
    end

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (out_load)
            result_reg <= step_result;
    end

    assign out_valid = out_valid_reg;
    assign duty      = result_reg.duty;
    assign action    = result_reg.action;
    assign remaining = result_reg.remaining;
    assign tally     = result_reg.tally;
    assign light_on  = result_reg.light_on;

`ifndef SYNTHESIS
    // Light-on action leaves the light lit
    a_on_lit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action == ACT_LIGHT_ON) |-> light_on)
        else $error("light on action with light off");

    // Light-off action leaves the light dark
    a_off_dark: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action == ACT_LIGHT_OFF) |-> !light_on)
        else $error("light off action with light on");

    // Remaining is zero unless it is being shown
    a_remaining_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action != ACT_SHOW_REMAINING) |-> (remaining == 8'd0))
        else $error("remaining set without show action");

    // Input only stalls when both registers are full and the output is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> in_valid_reg && out_valid_reg && !out_ready)
        else $error("input stalled without output back-pressure");
`endif

endmodule

// File: hdl/bgc_cfg.sv
// Configuration register file for the button gesture counter.
module bgc_cfg
    import bgc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output bgc_cfg_t    cfg
);

    logic [15:0] debounce_reg;
    logic [7:0]  prescale_reg;
    logic [7:0]  modulus_reg;

    // Write the addressed register; drop writes to unused indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
            prescale_reg <= PRESCALE_RESET;
            modulus_reg  <= MODULUS_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (bgc_cfg_idx_t'(cfg_index))
                CFG_DEBOUNCE: debounce_reg <= cfg_data;
                CFG_PRESCALE: prescale_reg <= cfg_data[7:0];
                CFG_MODULUS:  modulus_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    assign cfg.debounce_ticks = debounce_reg;
    assign cfg.fade_prescale  = prescale_reg;
    assign cfg.count_modulus  = modulus_reg;

endmodule

// File: hdl/bgc_engine.sv
// Debounce, fade and release classification state with its single-pass step logic.
module bgc_engine
    import bgc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  bgc_cfg_t    cfg,
    input  logic        step,
    input  logic        level,
    output bgc_result_t result
);

    logic        stable_level_reg, stable_level_next;
    logic        prev_sample_reg, prev_sample_next;
    logic [15:0] stable_ticks_reg, stable_ticks_next;
    logic        held_reg, held_next;
    logic [7:0]  prescale_ticks_reg, prescale_ticks_next;
    logic [7:0]  fade_step_reg, fade_step_next;
    logic [7:0]  fade_level_reg, fade_level_next;
    logic [7:0]  counter_reg, counter_next;
    logic        lamp_reg, lamp_next;
    logic [7:0]  duty_hold_reg, duty_hold_next;

    logic        sample;
    logic        release_evt;
    logic [7:0]  pt_inc;
    logic [8:0]  modulus_m1;
    logic [8:0]  counter_inc;
    bgc_action_t action_next;
    logic [7:0]  remaining_next;

    // Compute the state after one tick
    always_comb
    begin
        sample              = ~level;
        release_evt         = 1'b0;
        stable_level_next   = stable_level_reg;
        prev_sample_next    = prev_sample_reg;
        stable_ticks_next   = stable_ticks_reg;
        held_next           = held_reg;
        prescale_ticks_next = prescale_ticks_reg;
        fade_step_next      = fade_step_reg;
        fade_level_next     = fade_level_reg;
        counter_next        = counter_reg;
        lamp_next           = lamp_reg;
        duty_hold_next      = duty_hold_reg;
        action_next         = ACT_NONE;
        remaining_next      = 8'd0;
        pt_inc              = prescale_ticks_reg + 8'd1;
        modulus_m1          = {1'b0, cfg.count_modulus} - 9'd1;
        counter_inc         = {1'b0, counter_reg} + 9'd1;

        if (sample != prev_sample_reg)
        begin
            // Restart the stability count on any edge
            stable_ticks_next = 16'd0;
            prev_sample_next  = sample;
        end
        else
        begin
            if (stable_ticks_reg != STABLE_MAX)
                stable_ticks_next = stable_ticks_reg + 16'd1;
            if ((stable_ticks_next > cfg.debounce_ticks) && (sample != stable_level_reg))
            begin
                if (sample)
                    held_next = 1'b1;
                else
                    release_evt = 1'b1;
                stable_level_next = sample;
            end

            // Advance the fade ramp while held
            if (held_next)
            begin
                prescale_ticks_next = pt_inc;
                if (pt_inc == cfg.fade_prescale)
                begin
                    prescale_ticks_next = 8'd0;
                    fade_step_next      = fade_step_reg + 8'd1;
                    if (fade_step_next == FADE_TOP)
                        fade_level_next = fade_level_reg + 8'd1;
                end
                duty_hold_next = FADE_TOP - fade_step_next;
            end
            else
            begin
                prescale_ticks_next = 8'd0;
                fade_step_next      = 8'd0;
                fade_level_next     = 8'd0;
            end
        end

        // Classify the release by lamp state and fade level
        if (release_evt)
        begin
            if (lamp_reg)
            begin
                lamp_next   = 1'b0;
                action_next = ACT_LIGHT_OFF;
            end
            else if (fade_level_next == 8'd0)
            begin
                action_next = ACT_SHOW_REMAINING;
                if ((cfg.count_modulus != 8'd0) && ({1'b0, counter_reg} < modulus_m1))
                    remaining_next = modulus_m1[7:0] - counter_reg;
            end
            else if (fade_level_next == 8'd1)
            begin
                action_next = ACT_COUNTED_UP;
                if (counter_inc >= {1'b0, cfg.count_modulus})
                    counter_next = 8'd0;
                else
                    counter_next = counter_inc[7:0];
            end
            else
            begin
                action_next = ACT_LIGHT_ON;
                lamp_next   = 1'b1;
            end
            held_next           = 1'b0;
            prescale_ticks_next = 8'd0;
            fade_step_next      = 8'd0;
            fade_level_next     = 8'd0;
            duty_hold_next      = 8'd0;
        end
    end

    // Hold state between ticks, advance on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_level_reg   <= 1'b0;
            prev_sample_reg    <= 1'b0;
            stable_ticks_reg   <= 16'd0;
            held_reg           <= 1'b0;
            prescale_ticks_reg <= 8'd0;
            fade_step_reg      <= 8'd0;
            fade_level_reg     <= 8'd0;
            counter_reg        <= 8'd0;
            lamp_reg           <= 1'b0;
            duty_hold_reg      <= 8'd0;
        end
        else if (step)
        begin
            stable_level_reg   <= stable_level_next;
            prev_sample_reg    <= prev_sample_next;
            stable_ticks_reg   <= stable_ticks_next;
            held_reg           <= held_next;
            prescale_ticks_reg <= prescale_ticks_next;
            fade_step_reg      <= fade_step_next;
            fade_level_reg     <= fade_level_next;
            counter_reg        <= counter_next;
            lamp_reg           <= lamp_next;
            duty_hold_reg      <= duty_hold_next;
        end
    end

    assign result.duty      = duty_hold_next;
    assign result.action    = action_next;
    assign result.remaining = remaining_next;
    assign result.tally     = counter_next;
    assign result.light_on  = lamp_next;

`ifndef SYNTHESIS
    // A release always leaves the fade state cleared
    a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && release_evt |=> !held_reg && (fade_level_reg == 8'd0)
            && (duty_hold_reg == 8'd0))
        else $error("fade state not cleared after release");

    // The lamp only toggles on a release
    a_lamp_on_release: assert property (@(posedge clk) disable iff (!rst_n)
        step && !release_evt |=> $stable(lamp_reg))
        else $error("lamp changed without a release");

    // An edge on the sample never moves the fade ramp
    a_edge_freezes_fade: assert property (@(posedge clk) disable iff (!rst_n)
        step && (~level != prev_sample_reg) |=> $stable(fade_step_reg)
            && (stable_ticks_reg == 16'd0))
        else $error("fade advanced on a sample edge");
`endif

endmodule
